// ===== rtl/core/paired_output_completion_tracker_defines.svh =====
// Assertion macros for the paired output completion tracker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef PAIRED_OUTPUT_COMPLETION_TRACKER_DEFINES_SVH
`define PAIRED_OUTPUT_COMPLETION_TRACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define POCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define POCT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/poct_pkg.sv =====
// Package for the paired output completion tracker: payload types, codes,
// state type and default sizes. Depends on nothing.
`default_nettype none

package poct_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd2;
  localparam logic [2:0] STAT_MISMATCH  = 3'd3;
  localparam logic [2:0] STAT_CAPACITY  = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        frame_tag;
    logic signed [63:0] frame_pts;
    logic signed [63:0] encoder_stamp;
    logic               output_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] frame_pts;
    logic [63:0] encoder_stamp;
    logic        got_a;
    logic        got_b;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/paired_output_completion_tracker.sv =====
// Paired output completion tracker: pending frame table in one synchronous
// memory with a sequential key scan. Depends on poct_pkg and the defines header.
`default_nettype none
`include "paired_output_completion_tracker_defines.svh"

// Usage
//   Input channel (in_valid / in_stall / in_data): one transfer per item:
//   begin, record or clear. The block takes one item at a time and stalls
//   the input until that item's result has been loaded into the output reg.
//   Output channel (out_valid / out_stall / out_data): one result per item,
//   status and the occupancy after the item.
//   Config port (cfg_we / cfg_wdata): capacity limit, written while idle.
//   Sequence: begin and record scan every table entry through the memory read
//   port, one entry per cycle, then pass a drain step and the finish step,
//   which loads the output register. Clear and the unused action go straight
//   to the finish step. The single memory read port sets the scan's pace.
//   Overlap: the next item can transfer in the cycle in which out_valid rises;
//   the block does not take a new item before the last one's result is loaded.
//   Stall: a finished result waits in the output register; a further result
//   is held back in the finish step until the receiver takes the pending one.
//   Reset: all valid bits and the count clear at once, the limit returns to
//   16; entry payloads are kept, since only valid entries can match.
module paired_output_completion_tracker #(
  parameter int MAX_ENTRIES = poct_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire poct_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output poct_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata
);
  import poct_pkg::*;

  localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int LW   = (CW > 5) ? CW : 5;

  // Control and capture registers
  state_t            state_r, state_nxt;
  logic [4:0]        cap_r;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  in_item_t          item_r;
  logic [IDXW-1:0]   scan_idx_r;
  logic              cmp_live_r;
  logic              cmp_valid_r;
  logic [IDXW-1:0]   cmp_idx_r;
  logic              hit_r;
  logic [IDXW-1:0]   hit_idx_r;
  entry_t            hit_ent_r;
  logic              free_found_r;
  logic [IDXW-1:0]   free_idx_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Table memory
  entry_t            mem [MAX_ENTRIES];
  entry_t            rd_data_r;
  logic              mem_we;
  logic [IDXW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  logic              in_xfer;
  logic              out_xfer;
  logic              fin_go;
  logic              scan_last;
  logic              cmp_hit;
  logic [2:0]        status_nxt;
  logic [LW-1:0]     count_ext;
  logic [LW-1:0]     limit_ext;
  logic              slot_marked;
  logic              new_a;
  logic              new_b;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign scan_last = (scan_idx_r == IDXW'(MAX_ENTRIES - 1));
  assign cmp_hit   = cmp_live_r && cmp_valid_r && (rd_data_r.key == item_r.frame_tag);
  assign fin_go    = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == ACT_BEGIN || in_data.action == ACT_RECORD) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Resolve the item in the finish step, after any scan: status, table update, count
  always_comb begin
    count_ext   = LW'(count_r);
    limit_ext   = (LW'(cap_r) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(cap_r);
    slot_marked = item_r.output_slot ? hit_ent_r.got_b : hit_ent_r.got_a;
    new_a       = hit_ent_r.got_a | ~item_r.output_slot;
    new_b       = hit_ent_r.got_b | item_r.output_slot;

    status_nxt  = STAT_ACCEPTED;
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_r;
    mem_wdata.key           = item_r.frame_tag;
    mem_wdata.frame_pts     = item_r.frame_pts;
    mem_wdata.encoder_stamp = item_r.encoder_stamp;
    mem_wdata.got_a         = 1'b0;
    mem_wdata.got_b         = 1'b0;

    case (item_r.action)
      ACT_BEGIN: begin
        if (hit_r) begin
          status_nxt = STAT_DUPLICATE;
        end else if (count_ext >= limit_ext || !free_found_r) begin
          status_nxt = STAT_CAPACITY;
        end else begin
          mem_we                = fin_go;
          mem_waddr             = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt             = count_r + CW'(1);
        end
      end
      ACT_RECORD: begin
        if (!hit_r) begin
          status_nxt = STAT_UNKNOWN;
        end else if (hit_ent_r.frame_pts != item_r.frame_pts ||
                     hit_ent_r.encoder_stamp != item_r.encoder_stamp) begin
          status_nxt = STAT_MISMATCH;
        end else if (slot_marked) begin
          status_nxt = STAT_DUPLICATE;
        end else begin
          mem_we          = fin_go;
          mem_wdata.got_a = new_a;
          mem_wdata.got_b = new_b;
          if (new_a && new_b) begin
            // Both outputs seen: free the entry
            valid_nxt[hit_idx_r] = 1'b0;
            count_nxt            = count_r - CW'(1);
          end
        end
      end
      ACT_CLEAR: begin
        valid_nxt = '0;
        count_nxt = '0;
      end
      default: begin
        // Unused action: no change
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_RESET;
      valid_r      <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      cmp_live_r   <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmp_live_r <= (state_r == S_SCAN);
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_xfer) begin
        scan_idx_r   <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (state_r == S_SCAN) begin
          scan_idx_r <= scan_idx_r + IDXW'(1);
        end
        if (cmp_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (cmp_live_r && !cmp_valid_r && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (fin_go) begin
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: item, scan pipeline, captured entry, result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    cmp_valid_r <= valid_r[scan_idx_r];
    cmp_idx_r   <= scan_idx_r;
    if (cmp_hit && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_ent_r <= rd_data_r;
    end
    if (cmp_live_r && !cmp_valid_r && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (fin_go) begin
      out_data_r.status    <= status_nxt;
      out_data_r.occupancy <= 5'(LW'(count_nxt));
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  `POCT_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_r) == int'(count_r), "count and valid bits disagree")
  `POCT_ASSERT_ALWAYS(a_count_bounded, int'(count_r) <= MAX_ENTRIES, "occupancy above table size")
  `POCT_ASSERT_NEXT(a_finish_waits, (state_r == S_FINISH) && out_valid_r && out_stall, (state_r == S_FINISH) && out_valid_r, "result overwrote a pending output")
  `POCT_ASSERT_NEXT(a_busy_after_accept, in_xfer, state_r != S_IDLE, "accepted item left no work")

endmodule

`default_nettype wire
